### rtl/core/assert_macros.svh
// Assertion macros used by the fractal value noise top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### rtl/core/fvn_pkg.sv
// Package with constants and types of the fractal value noise block.
package fvn_pkg;
	localparam int FRAC_BITS_DEF = 24;
	localparam int NUM_OCT = 3;
	localparam int NUM_CORNERS = 4;
	localparam logic [63:0] MUL_A = 64'd374761393;
	localparam logic [63:0] MUL_B = 64'd668265263;
	localparam logic [63:0] MUL_C = 64'd2147483647;
	localparam logic [63:0] MIX_MUL = 64'd1274126177;
	localparam logic [31:0] SEED_A = 32'd17;
	localparam logic [31:0] SEED_B = 32'd31;
	localparam logic [31:0] SEED_C = 32'd13;
	localparam logic [23:0] OUT_MAX = 24'hFFFFFF;
	localparam logic [2:0] REG_COARSE_SHIFT = 3'd0;
	localparam logic [2:0] REG_SEED_COARSE = 3'd1;
	localparam logic [2:0] REG_SEED_MIDDLE = 3'd2;
	localparam logic [2:0] REG_SEED_FINE = 3'd3;
	localparam logic [2:0] REG_WEIGHT_COARSE = 3'd4;
	localparam logic [2:0] REG_WEIGHT_MIDDLE = 3'd5;
	localparam logic [2:0] REG_WEIGHT_FINE = 3'd6;
endpackage

### rtl/core/fractal_value_noise_2d.sv
// Top level of the three-octave fractal value noise pipeline.
// The done strobe rises together with the result of an accepted start on noise_value.
// Throughput: one word per cycle; busy is tied low since the receiver cannot stall.
// The rate is set by the pipeline itself: every stage takes a new word each cycle.
// Reset clears all valid bits and loads the register defaults; payload registers keep
// whatever they hold.
`include "assert_macros.svh"
module fractal_value_noise_2d #(
	parameter int VALUE_FRACTION_BITS = fvn_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  world_x,
	input  logic signed [31:0]  world_z,
	output logic                done,
	output logic        [23:0]  noise_value,
	input  logic                cfg_we,
	input  logic        [2:0]   cfg_index,
	input  logic        [15:0]  cfg_data
);
	import fvn_pkg::*;

	localparam int F = VALUE_FRACTION_BITS;
	localparam int L = 14;

	// Configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it.
	logic [3:0]  coarse_shift_q;
	logic [15:0] seed_q [NUM_OCT];
	logic [15:0] weight_q [NUM_OCT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coarse_shift_q <= 4'd4;
			seed_q[0] <= 16'd19;
			seed_q[1] <= 16'd37;
			seed_q[2] <= 16'd73;
			weight_q[0] <= 16'd36045;
			weight_q[1] <= 16'd19661;
			weight_q[2] <= 16'd9830;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COARSE_SHIFT: coarse_shift_q <= cfg_data[3:0];
				REG_SEED_COARSE: seed_q[0] <= cfg_data;
				REG_SEED_MIDDLE: seed_q[1] <= cfg_data;
				REG_SEED_FINE: seed_q[2] <= cfg_data;
				REG_WEIGHT_COARSE: weight_q[0] <= cfg_data;
				REG_WEIGHT_MIDDLE: weight_q[1] <= cfg_data;
				REG_WEIGHT_FINE: weight_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The block never refuses a word.
	assign busy = 1'b0;

	// Valid bits travel down the pipe with the data.
	logic [L-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[L-2:0], start & ~busy};
	end

	// Stage 1: split each coordinate into cell and fraction per octave and offset the
	// cell coordinates by the seeds. Corner order: (x0,z0) (x1,z0) (x0,z1) (x1,z1).
	logic [31:0]  ca_s1 [NUM_OCT][NUM_CORNERS];
	logic [31:0]  cb_s1 [NUM_OCT];
	logic [31:0]  cc_s1 [NUM_OCT][NUM_CORNERS];
	logic [F-1:0] fx_s1 [NUM_OCT];
	logic [F-1:0] fz_s1 [NUM_OCT];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++) begin
			logic [4:0]  si;
			logic [3:0]  sh;
			logic [31:0] seed, cx, cz, ax0, cz0, msk;
			si = {1'b0, coarse_shift_q} - 5'(k);
			sh = si[4] ? 4'd0 : si[3:0];
			seed = {{16{seed_q[k][15]}}, seed_q[k]};
			cx = 32'($signed(world_x) >>> sh);
			cz = 32'($signed(world_z) >>> sh);
			msk = (32'd1 << sh) - 32'd1;
			ax0 = cx + seed * SEED_A;
			cz0 = cz - seed * SEED_C;
			ca_s1[k][0] <= ax0;
			ca_s1[k][1] <= ax0 + 32'd1;
			ca_s1[k][2] <= ax0;
			ca_s1[k][3] <= ax0 + 32'd1;
			cc_s1[k][0] <= cz0;
			cc_s1[k][1] <= cz0;
			cc_s1[k][2] <= cz0 + 32'd1;
			cc_s1[k][3] <= cz0 + 32'd1;
			cb_s1[k] <= seed * SEED_B;
			fx_s1[k] <= F'(({32'd0, 32'(world_x) & msk}) << (F - 32'(sh)));
			fz_s1[k] <= F'(({32'd0, 32'(world_z) & msk}) << (F - 32'(sh)));
		end
	end

	// Stage 2: the three linear hash products; smoothstep squares.
	logic [63:0] pa_s2 [NUM_OCT][NUM_CORNERS];
	logic [63:0] pb_s2 [NUM_OCT];
	logic [63:0] pc_s2 [NUM_OCT][NUM_CORNERS];
	logic [F-1:0] fx_s2 [NUM_OCT];
	logic [F-1:0] fz_s2 [NUM_OCT];
	logic [F-1:0] tx2_s2 [NUM_OCT];
	logic [F-1:0] tz2_s2 [NUM_OCT];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++) begin
			for (int c = 0; c < NUM_CORNERS; c++) begin
				pa_s2[k][c] <= {32'd0, ca_s1[k][c]} * MUL_A;
				pc_s2[k][c] <= {32'd0, cc_s1[k][c]} * MUL_C;
			end
			pb_s2[k] <= {32'd0, cb_s1[k]} * MUL_B;
			fx_s2[k] <= fx_s1[k];
			fz_s2[k] <= fz_s1[k];
			tx2_s2[k] <= F'(({(2*F)'(0), fx_s1[k]} * {(2*F)'(0), fx_s1[k]}) >> F);
			tz2_s2[k] <= F'(({(2*F)'(0), fz_s1[k]} * {(2*F)'(0), fz_s1[k]}) >> F);
		end
	end

	// Stage 3: sum the hash products; smoothstep cubes.
	logic [63:0] h_s3 [NUM_OCT][NUM_CORNERS];
	logic [F-1:0] tx2_s3 [NUM_OCT], tz2_s3 [NUM_OCT];
	logic [F-1:0] tx3_s3 [NUM_OCT], tz3_s3 [NUM_OCT];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++) begin
			for (int c = 0; c < NUM_CORNERS; c++)
				h_s3[k][c] <= pa_s2[k][c] + pb_s2[k] + pc_s2[k][c];
			tx2_s3[k] <= tx2_s2[k];
			tz2_s3[k] <= tz2_s2[k];
			tx3_s3[k] <= F'(({(2*F)'(0), tx2_s2[k]} * {(2*F)'(0), fx_s2[k]}) >> F);
			tz3_s3[k] <= F'(({(2*F)'(0), tz2_s2[k]} * {(2*F)'(0), fz_s2[k]}) >> F);
		end
	end

	// Stage 4: xor-shift and the partial products of the mixing multiply (low 32 bits
	// times the constant and high 32 bits times the constant).
	logic [63:0] ml_s4 [NUM_OCT][NUM_CORNERS];
	logic [63:0] mh_s4 [NUM_OCT][NUM_CORNERS];
	logic [F-1:0] sx_s4 [NUM_OCT], sz_s4 [NUM_OCT];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++) begin
			logic [F+2:0] sx, sz;
			for (int c = 0; c < NUM_CORNERS; c++) begin
				logic [63:0] x;
				x = h_s3[k][c] ^ (h_s3[k][c] >> 13);
				ml_s4[k][c] <= {32'd0, x[31:0]} * MIX_MUL;
				mh_s4[k][c] <= {32'd0, x[63:32]} * MIX_MUL;
			end
			sx = (F+3)'(3) * (F+3)'(tx2_s3[k]) - (F+3)'(2) * (F+3)'(tx3_s3[k]);
			sz = (F+3)'(3) * (F+3)'(tz2_s3[k]) - (F+3)'(2) * (F+3)'(tz3_s3[k]);
			sx_s4[k] <= (sx[F+2] || sx[F+1:F] != 2'd0) ? {F{1'b1}} : sx[F-1:0];
			sz_s4[k] <= (sz[F+2] || sz[F+1:F] != 2'd0) ? {F{1'b1}} : sz[F-1:0];
		end
	end

	// Stage 5: finish the mix and take the lattice values.
	logic [F-1:0] lv_s5 [NUM_OCT][NUM_CORNERS];
	logic [F-1:0] sx_s5 [NUM_OCT], sz_s5 [NUM_OCT];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++) begin
			for (int c = 0; c < NUM_CORNERS; c++) begin
				logic [63:0] m;
				m = ml_s4[k][c] + {mh_s4[k][c][31:0], 32'd0};
				m = m ^ (m >> 16);
				lv_s5[k][c] <= m[F-1:0];
			end
			sx_s5[k] <= sx_s4[k];
			sz_s5[k] <= sz_s4[k];
		end
	end

	// Stages 6-7: row blends along x. Stage 6 forms the difference and the product,
	// stage 7 applies the correction.
	logic [F-1:0] ra_s6 [NUM_OCT][2];
	logic         rn_s6 [NUM_OCT][2];
	logic [2*F-1:0] rp_s6 [NUM_OCT][2];
	logic [F-1:0] sz_s6 [NUM_OCT];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++) begin
			for (int r = 0; r < 2; r++) begin
				logic [F-1:0] a, b, d;
				a = lv_s5[k][2*r];
				b = lv_s5[k][2*r+1];
				d = (b >= a) ? b - a : a - b;
				ra_s6[k][r] <= a;
				rn_s6[k][r] <= (b < a);
				rp_s6[k][r] <= {{F{1'b0}}, d} * {{F{1'b0}}, sx_s5[k]};
			end
			sz_s6[k] <= sz_s5[k];
		end
	end

	logic [F-1:0] row_s7 [NUM_OCT][2];
	logic [F-1:0] sz_s7 [NUM_OCT];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++) begin
			for (int r = 0; r < 2; r++)
				row_s7[k][r] <= rn_s6[k][r] ? ra_s6[k][r] - rp_s6[k][r][2*F-1:F]
					: ra_s6[k][r] + rp_s6[k][r][2*F-1:F];
			sz_s7[k] <= sz_s6[k];
		end
	end

	// Stages 8-9: blend the two rows along z.
	logic [F-1:0]   za_s8 [NUM_OCT];
	logic           zn_s8 [NUM_OCT];
	logic [2*F-1:0] zp_s8 [NUM_OCT];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++) begin
			logic [F-1:0] a, b, d;
			a = row_s7[k][0];
			b = row_s7[k][1];
			d = (b >= a) ? b - a : a - b;
			za_s8[k] <= a;
			zn_s8[k] <= (b < a);
			zp_s8[k] <= {{F{1'b0}}, d} * {{F{1'b0}}, sz_s7[k]};
		end
	end

	logic [F-1:0] ov_s9 [NUM_OCT];
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++)
			ov_s9[k] <= zn_s8[k] ? za_s8[k] - zp_s8[k][2*F-1:F]
				: za_s8[k] + zp_s8[k][2*F-1:F];
	end

	// Stage 10: weight each octave; stage 11: sum; stage 12: scale; stage 13: saturate.
	logic [F+15:0] wp_s10 [NUM_OCT];
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_OCT; k++)
			wp_s10[k] <= {16'd0, ov_s9[k]} * {{F{1'b0}}, weight_q[k]};
	end

	logic [F+17:0] sum_s11;
	always_ff @(posedge clk)
		sum_s11 <= (F+18)'(wp_s10[0]) + (F+18)'(wp_s10[1]) + (F+18)'(wp_s10[2]);

	// The sum is Q2.F after dropping 16 bits; line it up with 24 fraction bits.
	logic [F+33:0] scl_s12;
	always_ff @(posedge clk) begin
		logic [F+33:0] q;
		q = (F+34)'(sum_s11 >> 16);
		if (F >= 24) scl_s12 <= q >> (F - 24);
		else scl_s12 <= q << (24 - F);
	end

	logic [23:0] res_s13;
	always_ff @(posedge clk)
		res_s13 <= (scl_s12 > (F+34)'(OUT_MAX)) ? OUT_MAX : scl_s12[23:0];

	// Output word register.
	logic [23:0] out_s14;
	always_ff @(posedge clk) out_s14 <= res_s13;

	assign done = vld_q[L-1];
	assign noise_value = out_s14;

	`ASSERT_NEXT(a_start_enters, clk, arst_n, start, vld_q[0])
	`ASSERT_IMPL(a_busy_low, clk, arst_n, 1'b1, !busy)
	`ASSERT_NEXT(a_valid_shifts, clk, arst_n, vld_q[L-2], done)
endmodule
